// ===== sv/fjspr_pkg.sv =====
// Shared types, codes and helper functions for the four-joint servo pose ramper.
`timescale 1ns / 1ps
`default_nettype none

package fjspr_pkg;

    localparam int ANGLE_W  = 8;
    localparam int PERIOD_W = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE = 8'd180;

    // Input opcodes
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_POSE = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    // Pose codes
    localparam logic [1:0] POSE_SIT      = 2'd0;
    localparam logic [1:0] POSE_STAND    = 2'd1;
    localparam logic [1:0] POSE_STEP     = 2'd2;
    localparam logic [1:0] POSE_STEP_SIT = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_STAND_ANGLE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIT_HIP_ANGLE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIT_ANKLE_ANGLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_STEP_HIP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_STEP_HIP   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STAND_HIP_PERIOD = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SIT_HIP_PERIOD   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANKLE_PERIOD     = 3'd7;

    // Reset values
    localparam logic [ANGLE_W-1:0]  RST_STAND_ANGLE      = 8'd90;
    localparam logic [ANGLE_W-1:0]  RST_SIT_HIP_ANGLE    = 8'd0;
    localparam logic [ANGLE_W-1:0]  RST_SIT_ANKLE_ANGLE  = 8'd0;
    localparam logic [ANGLE_W-1:0]  RST_LEFT_STEP_HIP    = 8'd90;
    localparam logic [ANGLE_W-1:0]  RST_RIGHT_STEP_HIP   = 8'd90;
    localparam logic [PERIOD_W-1:0] RST_STAND_HIP_PERIOD = 8'd60;
    localparam logic [PERIOD_W-1:0] RST_SIT_HIP_PERIOD   = 8'd15;
    localparam logic [PERIOD_W-1:0] RST_ANKLE_PERIOD     = 8'd30;

    typedef struct packed {
        logic [ANGLE_W-1:0]  stand_angle;
        logic [ANGLE_W-1:0]  sit_hip_angle;
        logic [ANGLE_W-1:0]  sit_ankle_angle;
        logic [ANGLE_W-1:0]  left_step_hip_angle;
        logic [ANGLE_W-1:0]  right_step_hip_angle;
        logic [PERIOD_W-1:0] stand_hip_period;
        logic [PERIOD_W-1:0] sit_hip_period;
        logic [PERIOD_W-1:0] ankle_period;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         pose;
        logic               left_side;
        logic [ANGLE_W-1:0] set_left_hip;
        logic [ANGLE_W-1:0] set_left_ankle;
        logic [ANGLE_W-1:0] set_right_hip;
        logic [ANGLE_W-1:0] set_right_ankle;
    } item_t;

    typedef struct packed {
        logic [ANGLE_W-1:0] left_hip;
        logic [ANGLE_W-1:0] left_ankle;
        logic [ANGLE_W-1:0] right_hip;
        logic [ANGLE_W-1:0] right_ankle;
        logic               ramp_busy;
    } result_t;

    function automatic logic [ANGLE_W-1:0] sat_angle(input logic [ANGLE_W-1:0] v);
        return (v > MAX_ANGLE) ? MAX_ANGLE : v;
    endfunction

    function automatic logic [ANGLE_W-1:0] toward(input logic [ANGLE_W-1:0] cur,
                                                  input logic [ANGLE_W-1:0] tgt);
        logic [ANGLE_W-1:0] r;
        r = cur;
        if (cur < tgt)
        begin
            r = cur + 8'd1;
        end
        else if (cur > tgt)
        begin
            r = cur - 8'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/fjspr_cfg_regs.sv =====
// Configuration register file for the pose ramper.
`timescale 1ns / 1ps
`default_nettype none

module fjspr_cfg_regs
    import fjspr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ANGLE_W-1:0]   cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                REG_STAND_ANGLE:      cfg_next.stand_angle          = cfg_data;
                REG_SIT_HIP_ANGLE:    cfg_next.sit_hip_angle        = cfg_data;
                REG_SIT_ANKLE_ANGLE:  cfg_next.sit_ankle_angle      = cfg_data;
                REG_LEFT_STEP_HIP:    cfg_next.left_step_hip_angle  = cfg_data;
                REG_RIGHT_STEP_HIP:   cfg_next.right_step_hip_angle = cfg_data;
                REG_STAND_HIP_PERIOD: cfg_next.stand_hip_period     = cfg_data;
                REG_SIT_HIP_PERIOD:   cfg_next.sit_hip_period       = cfg_data;
                REG_ANKLE_PERIOD:     cfg_next.ankle_period         = cfg_data;
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.stand_angle          <= RST_STAND_ANGLE;
            cfg_reg.sit_hip_angle        <= RST_SIT_HIP_ANGLE;
            cfg_reg.sit_ankle_angle      <= RST_SIT_ANKLE_ANGLE;
            cfg_reg.left_step_hip_angle  <= RST_LEFT_STEP_HIP;
            cfg_reg.right_step_hip_angle <= RST_RIGHT_STEP_HIP;
            cfg_reg.stand_hip_period     <= RST_STAND_HIP_PERIOD;
            cfg_reg.sit_hip_period       <= RST_SIT_HIP_PERIOD;
            cfg_reg.ankle_period         <= RST_ANKLE_PERIOD;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/fjspr_core.sv =====
// Joint state, ramp timers and the per-item update logic.
`timescale 1ns / 1ps
`default_nettype none

module fjspr_core
    import fjspr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  fire,
    input  wire item_t item,
    input  wire cfg_t  cfg,
    output result_t    result,
    output result_t    state
);

    logic [ANGLE_W-1:0]  lh_reg, la_reg, rh_reg, ra_reg;
    logic [ANGLE_W-1:0]  lh_next, la_next, rh_next, ra_next;
    logic [ANGLE_W-1:0]  hip_tgt_reg, ankle_tgt_reg, hip_tgt_next, ankle_tgt_next;
    logic [PERIOD_W-1:0] hip_cnt_reg, ankle_cnt_reg, hip_cnt_next, ankle_cnt_next;
    logic                ramping_reg, ramping_next;
    logic                is_sit_reg, is_sit_next;

    logic [PERIOD_W-1:0] hip_period;
    logic [PERIOD_W:0]   hip_cnt_inc, ankle_cnt_inc;
    logic [ANGLE_W-1:0]  st_sat, new_hip_tgt, new_ankle_tgt;
    logic                new_sit;

    assign hip_period    = is_sit_reg ? cfg.sit_hip_period : cfg.stand_hip_period;
    assign hip_cnt_inc   = {1'b0, hip_cnt_reg} + 9'd1;
    assign ankle_cnt_inc = {1'b0, ankle_cnt_reg} + 9'd1;
    assign st_sat        = sat_angle(cfg.stand_angle);
    assign new_sit       = (item.pose == POSE_SIT);
    assign new_hip_tgt   = new_sit ? sat_angle(cfg.sit_hip_angle) : st_sat;
    assign new_ankle_tgt = new_sit ? sat_angle(cfg.sit_ankle_angle) : st_sat;

    always_comb
    begin
        lh_next        = lh_reg;
        la_next        = la_reg;
        rh_next        = rh_reg;
        ra_next        = ra_reg;
        hip_tgt_next   = hip_tgt_reg;
        ankle_tgt_next = ankle_tgt_reg;
        hip_cnt_next   = hip_cnt_reg;
        ankle_cnt_next = ankle_cnt_reg;
        ramping_next   = ramping_reg;
        is_sit_next    = is_sit_reg;

        case (item.opcode)
            OP_TICK:
            begin
                if (ramping_reg)
                begin
                    // A period of zero compares as reached on every tick.
                    if (hip_cnt_inc >= {1'b0, hip_period})
                    begin
                        lh_next      = toward(lh_reg, hip_tgt_reg);
                        rh_next      = toward(rh_reg, hip_tgt_reg);
                        hip_cnt_next = '0;
                    end
                    else
                    begin
                        hip_cnt_next = hip_cnt_inc[PERIOD_W-1:0];
                    end
                    if (ankle_cnt_inc >= {1'b0, cfg.ankle_period})
                    begin
                        la_next        = toward(la_reg, ankle_tgt_reg);
                        ra_next        = toward(ra_reg, ankle_tgt_reg);
                        ankle_cnt_next = '0;
                    end
                    else
                    begin
                        ankle_cnt_next = ankle_cnt_inc[PERIOD_W-1:0];
                    end
                    ramping_next = !(lh_next == hip_tgt_reg && rh_next == hip_tgt_reg &&
                                     la_next == ankle_tgt_reg && ra_next == ankle_tgt_reg);
                end
            end
            OP_POSE:
            begin
                if (!ramping_reg)
                begin
                    case (item.pose)
                        POSE_SIT, POSE_STAND:
                        begin
                            is_sit_next    = new_sit;
                            hip_tgt_next   = new_hip_tgt;
                            ankle_tgt_next = new_ankle_tgt;
                            hip_cnt_next   = '0;
                            ankle_cnt_next = '0;
                            ramping_next   = !(lh_reg == new_hip_tgt && rh_reg == new_hip_tgt &&
                                               la_reg == new_ankle_tgt &&
                                               ra_reg == new_ankle_tgt);
                        end
                        POSE_STEP:
                        begin
                            lh_next = st_sat;
                            la_next = st_sat;
                            rh_next = st_sat;
                            ra_next = st_sat;
                            if (item.left_side)
                            begin
                                lh_next = sat_angle(cfg.left_step_hip_angle);
                            end
                            else
                            begin
                                rh_next = sat_angle(cfg.right_step_hip_angle);
                            end
                        end
                        default:
                        begin
                            // Step in place: the moving leg takes the sit angles.
                            lh_next = st_sat;
                            la_next = st_sat;
                            rh_next = st_sat;
                            ra_next = st_sat;
                            if (item.left_side)
                            begin
                                lh_next = sat_angle(cfg.sit_hip_angle);
                                la_next = sat_angle(cfg.sit_ankle_angle);
                            end
                            else
                            begin
                                rh_next = sat_angle(cfg.sit_hip_angle);
                                ra_next = sat_angle(cfg.sit_ankle_angle);
                            end
                        end
                    endcase
                end
            end
            OP_SET:
            begin
                if (!ramping_reg)
                begin
                    lh_next = sat_angle(item.set_left_hip);
                    la_next = sat_angle(item.set_left_ankle);
                    rh_next = sat_angle(item.set_right_hip);
                    ra_next = sat_angle(item.set_right_ankle);
                end
            end
            default:
            begin
                lh_next = lh_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lh_reg        <= RST_STAND_ANGLE;
            la_reg        <= RST_STAND_ANGLE;
            rh_reg        <= RST_STAND_ANGLE;
            ra_reg        <= RST_STAND_ANGLE;
            hip_tgt_reg   <= '0;
            ankle_tgt_reg <= '0;
            hip_cnt_reg   <= '0;
            ankle_cnt_reg <= '0;
            ramping_reg   <= 1'b0;
            is_sit_reg    <= 1'b0;
        end
        else if (fire)
        begin
            lh_reg        <= lh_next;
            la_reg        <= la_next;
            rh_reg        <= rh_next;
            ra_reg        <= ra_next;
            hip_tgt_reg   <= hip_tgt_next;
            ankle_tgt_reg <= ankle_tgt_next;
            hip_cnt_reg   <= hip_cnt_next;
            ankle_cnt_reg <= ankle_cnt_next;
            ramping_reg   <= ramping_next;
            is_sit_reg    <= is_sit_next;
        end
    end

    assign result.left_hip    = lh_next;
    assign result.left_ankle  = la_next;
    assign result.right_hip   = rh_next;
    assign result.right_ankle = ra_next;
    assign result.ramp_busy   = ramping_next;

    assign state.left_hip    = lh_reg;
    assign state.left_ankle  = la_reg;
    assign state.right_hip   = rh_reg;
    assign state.right_ankle = ra_reg;
    assign state.ramp_busy   = ramping_reg;

endmodule

`default_nettype wire

// ===== sv/four_joint_servo_pose_ramper.sv =====
// Top level of the four-joint servo pose ramper: input register, core and result register.
// Path: an item goes through the input register and then the result register; the joint
// update is combinational logic in the core, fed back into the core's state registers.
// Throughput: one item per cycle while the result register is free to take it.
// Reset: rst_n clears the pipeline, sets all joints to 90 degrees, clears the ramp state
// and loads the configuration registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module four_joint_servo_pose_ramper
    import fjspr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ANGLE_W-1:0]   cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           opcode,
    input  wire logic [1:0]           pose,
    input  wire logic                 left_side,
    input  wire logic [ANGLE_W-1:0]   set_left_hip,
    input  wire logic [ANGLE_W-1:0]   set_left_ankle,
    input  wire logic [ANGLE_W-1:0]   set_right_hip,
    input  wire logic [ANGLE_W-1:0]   set_right_ankle,

    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [ANGLE_W-1:0]        left_hip_out,
    output logic [ANGLE_W-1:0]        left_ankle_out,
    output logic [ANGLE_W-1:0]        right_hip_out,
    output logic [ANGLE_W-1:0]        right_ankle_out,
    output logic                      ramp_busy
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    result_t core_result;
    result_t core_state;
    result_t res_reg;
    logic    res_valid_reg;
    logic    res_free;
    logic    fire;

    fjspr_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The result register frees up in the same cycle its content transfers out.
    assign res_free = !res_valid_reg || out_ready;
    assign fire     = item_valid_reg && res_free;
    assign in_ready = !item_valid_reg || fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            item_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.opcode          <= opcode;
            item_reg.pose            <= pose;
            item_reg.left_side       <= left_side;
            item_reg.set_left_hip    <= set_left_hip;
            item_reg.set_left_ankle  <= set_left_ankle;
            item_reg.set_right_hip   <= set_right_hip;
            item_reg.set_right_ankle <= set_right_ankle;
        end
    end

    fjspr_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item_reg),
        .cfg    (cfg),
        .result (core_result),
        .state  (core_state)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (res_free)
        begin
            res_valid_reg <= fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            res_reg <= core_result;
        end
    end

    assign out_valid       = res_valid_reg;
    assign left_hip_out    = res_reg.left_hip;
    assign left_ankle_out  = res_reg.left_ankle;
    assign right_hip_out   = res_reg.right_hip;
    assign right_ankle_out = res_reg.right_ankle;
    assign ramp_busy       = res_reg.ramp_busy;

    // Joint state moves only when an item goes through the core.
    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(core_state))
        else $error("joint state changed without an item");

    // Commands during a ramp leave the joint angles alone.
    a_busy_ignores_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && core_state.ramp_busy && item_reg.opcode != OP_TICK)
        |=> $stable(core_state))
        else $error("command changed joints during a ramp");

    // Every joint stays within the servo range.
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        core_state.left_hip <= MAX_ANGLE && core_state.left_ankle <= MAX_ANGLE &&
        core_state.right_hip <= MAX_ANGLE && core_state.right_ankle <= MAX_ANGLE)
        else $error("joint angle out of range");

endmodule

`default_nettype wire

// ===== tb/four_joint_servo_pose_ramper_tb.sv =====
// Self-checking testbench for the four-joint servo pose ramper with a built-in pose predictor.
`timescale 1ns / 1ps

module four_joint_servo_pose_ramper_tb;
    import fjspr_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [ANGLE_W-1:0]   cfg_data = '0;

    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         opcode = '0;
    logic [1:0]         pose = '0;
    logic               left_side = 1'b0;
    logic [ANGLE_W-1:0] set_left_hip = '0;
    logic [ANGLE_W-1:0] set_left_ankle = '0;
    logic [ANGLE_W-1:0] set_right_hip = '0;
    logic [ANGLE_W-1:0] set_right_ankle = '0;

    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [ANGLE_W-1:0] left_hip_out;
    logic [ANGLE_W-1:0] left_ankle_out;
    logic [ANGLE_W-1:0] right_hip_out;
    logic [ANGLE_W-1:0] right_ankle_out;
    logic               ramp_busy;

    // Shadow of the configuration registers and of the joint state.
    cfg_t regs;
    logic [ANGLE_W-1:0] lh, la, rh, ra;
    logic [ANGLE_W-1:0] hip_tgt, ank_tgt;
    logic [7:0] hip_cnt, ank_cnt;
    bit ramp_on, ramp_sit;

    item_t   cmd_backlog[$];
    result_t expected_poses[$];
    item_t   drv_item;
    result_t want;

    bit idle_on = 1'b1;
    int gap_left = 0;
    int stall_left = 0;
    int errors = 0;
    int items_sent = 0;
    int results_checked = 0;
    int ramps_started = 0;
    int unsigned cycles = 0;

    four_joint_servo_pose_ramper dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .opcode          (opcode),
        .pose            (pose),
        .left_side       (left_side),
        .set_left_hip    (set_left_hip),
        .set_left_ankle  (set_left_ankle),
        .set_right_hip   (set_right_hip),
        .set_right_ankle (set_right_ankle),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .left_hip_out    (left_hip_out),
        .left_ankle_out  (left_ankle_out),
        .right_hip_out   (right_hip_out),
        .right_ankle_out (right_ankle_out),
        .ramp_busy       (ramp_busy)
    );

    always #4 clk = ~clk;

    function automatic logic [ANGLE_W-1:0] clip_angle(input logic [ANGLE_W-1:0] v);
        return (v > 8'd180) ? 8'd180 : v;
    endfunction

    function automatic logic [ANGLE_W-1:0] step_toward(input logic [ANGLE_W-1:0] cur,
                                                       input logic [ANGLE_W-1:0] tgt);
        if (cur < tgt)
        begin
            return cur + 8'd1;
        end
        if (cur > tgt)
        begin
            return cur - 8'd1;
        end
        return cur;
    endfunction

    function automatic bit on_target();
        return lh == hip_tgt && rh == hip_tgt && la == ank_tgt && ra == ank_tgt;
    endfunction

    // Applies one accepted command to the shadow joints and returns the pose it leaves.
    task automatic update_joints(input item_t it, output result_t r);
        logic [8:0] hc, ac, hper;
        logic [ANGLE_W-1:0] st;
        if (it.opcode == OP_TICK)
        begin
            if (ramp_on)
            begin
                hper = ramp_sit ? {1'b0, regs.sit_hip_period} : {1'b0, regs.stand_hip_period};
                hc = {1'b0, hip_cnt} + 9'd1;
                ac = {1'b0, ank_cnt} + 9'd1;
                if (hc >= hper)
                begin
                    lh = step_toward(lh, hip_tgt);
                    rh = step_toward(rh, hip_tgt);
                    hc = '0;
                end
                if (ac >= {1'b0, regs.ankle_period})
                begin
                    la = step_toward(la, ank_tgt);
                    ra = step_toward(ra, ank_tgt);
                    ac = '0;
                end
                hip_cnt = hc[7:0];
                ank_cnt = ac[7:0];
                if (on_target())
                begin
                    ramp_on = 1'b0;
                end
            end
        end
        else if (!ramp_on)
        begin
            if (it.opcode == OP_POSE)
            begin
                st = clip_angle(regs.stand_angle);
                if (it.pose == POSE_SIT || it.pose == POSE_STAND)
                begin
                    ramp_sit = (it.pose == POSE_SIT);
                    hip_tgt = ramp_sit ? clip_angle(regs.sit_hip_angle) : st;
                    ank_tgt = ramp_sit ? clip_angle(regs.sit_ankle_angle) : st;
                    hip_cnt = '0;
                    ank_cnt = '0;
                    ramp_on = !on_target();
                    if (ramp_on)
                    begin
                        ramps_started++;
                    end
                end
                else
                begin
                    lh = st;
                    la = st;
                    rh = st;
                    ra = st;
                    if (it.pose == POSE_STEP)
                    begin
                        if (it.left_side)
                        begin
                            lh = clip_angle(regs.left_step_hip_angle);
                        end
                        else
                        begin
                            rh = clip_angle(regs.right_step_hip_angle);
                        end
                    end
                    else if (it.left_side)
                    begin
                        lh = clip_angle(regs.sit_hip_angle);
                        la = clip_angle(regs.sit_ankle_angle);
                    end
                    else
                    begin
                        rh = clip_angle(regs.sit_hip_angle);
                        ra = clip_angle(regs.sit_ankle_angle);
                    end
                end
            end
            else if (it.opcode == OP_SET)
            begin
                lh = clip_angle(it.set_left_hip);
                la = clip_angle(it.set_left_ankle);
                rh = clip_angle(it.set_right_hip);
                ra = clip_angle(it.set_right_ankle);
            end
        end
        r.left_hip = lh;
        r.left_ankle = la;
        r.right_hip = rh;
        r.right_ankle = ra;
        r.ramp_busy = ramp_on;
    endtask

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (!idle_on || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 30));
    endfunction

    function automatic item_t make_cmd(input logic [1:0] op, input logic [1:0] ps,
                                       input logic lft, input int a, input int b,
                                       input int c, input int d);
        item_t it;
        it.opcode = op;
        it.pose = ps;
        it.left_side = lft;
        it.set_left_hip = a[7:0];
        it.set_left_ankle = b[7:0];
        it.set_right_hip = c[7:0];
        it.set_right_ankle = d[7:0];
        return it;
    endfunction

    function automatic int rand_angle();
        return int'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 180)
                                               : $urandom_range(0, 255));
    endfunction

    function automatic item_t random_cmd();
        return make_cmd(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                        1'($urandom_range(0, 1)),
                        rand_angle(), rand_angle(), rand_angle(), rand_angle());
    endfunction

    function automatic int near(input int t, input int d);
        int v;
        v = t + int'($urandom_range(0, 2 * d)) - d;
        return (v < 0) ? 0 : ((v > 180) ? 180 : v);
    endfunction

    function automatic int gap_deg(input int x, input int y);
        return (x < y) ? y - x : x - y;
    endfunction

    // Ticks carry random payload; now and then an unrelated command lands mid-ramp.
    task automatic add_ticks(input int n, output int added);
        added = 0;
        for (int k = 0; k < n; k++)
        begin
            cmd_backlog.push_back(make_cmd(OP_TICK, 2'($urandom_range(0, 3)),
                                           1'($urandom_range(0, 1)),
                                           int'($urandom_range(0, 255)),
                                           int'($urandom_range(0, 255)),
                                           int'($urandom_range(0, 255)),
                                           int'($urandom_range(0, 255))));
            added++;
            if ($urandom_range(0, 9) == 0)
            begin
                cmd_backlog.push_back(random_cmd());
                added++;
            end
        end
    endtask

    // A sit or stand ramp; seven times in eight from a pose placed near its targets and followed by enough ticks.
    task automatic add_ramp_seq(output int count);
        bit sit;
        int ht, at, hper, aper, dmax, a0, a1, a2, a3, n, extra;
        sit = 1'($urandom_range(0, 1));
        ht = int'(clip_angle(sit ? regs.sit_hip_angle : regs.stand_angle));
        at = int'(clip_angle(sit ? regs.sit_ankle_angle : regs.stand_angle));
        hper = int'(sit ? regs.sit_hip_period : regs.stand_hip_period);
        hper = (hper == 0) ? 1 : hper;
        aper = (regs.ankle_period == 0) ? 1 : int'(regs.ankle_period);
        dmax = (hper > 30 || aper > 30) ? 1 : ((hper > 4 || aper > 4) ? 3 : 10);
        count = 0;
        if ($urandom_range(0, 7) != 0)
        begin
            a0 = near(ht, dmax);
            a1 = near(at, dmax);
            a2 = near(ht, dmax);
            a3 = near(at, dmax);
            cmd_backlog.push_back(make_cmd(OP_SET, 2'($urandom_range(0, 3)),
                                           1'($urandom_range(0, 1)), a0, a1, a2, a3));
            count++;
            n = hper * ((gap_deg(a0, ht) > gap_deg(a2, ht)) ? gap_deg(a0, ht) : gap_deg(a2, ht));
            a0 = aper * ((gap_deg(a1, at) > gap_deg(a3, at)) ? gap_deg(a1, at) : gap_deg(a3, at));
            n = ((n > a0) ? n : a0) + int'($urandom_range(0, 4));
        end
        else
        begin
            n = int'($urandom_range(10, 60));
        end
        cmd_backlog.push_back(make_cmd(OP_POSE, sit ? POSE_SIT : POSE_STAND,
                                       1'($urandom_range(0, 1)), rand_angle(), rand_angle(),
                                       rand_angle(), rand_angle()));
        count++;
        add_ticks(n, extra);
        count += extra;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ANGLE_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        case (idx)
            REG_STAND_ANGLE:      regs.stand_angle = v;
            REG_SIT_HIP_ANGLE:    regs.sit_hip_angle = v;
            REG_SIT_ANKLE_ANGLE:  regs.sit_ankle_angle = v;
            REG_LEFT_STEP_HIP:    regs.left_step_hip_angle = v;
            REG_RIGHT_STEP_HIP:   regs.right_step_hip_angle = v;
            REG_STAND_HIP_PERIOD: regs.stand_hip_period = v;
            REG_SIT_HIP_PERIOD:   regs.sit_hip_period = v;
            default:              regs.ankle_period = v;
        endcase
    endtask

    task automatic program_regs(input cfg_t v);
        @(posedge clk);
        write_reg(REG_STAND_ANGLE, v.stand_angle);
        write_reg(REG_SIT_HIP_ANGLE, v.sit_hip_angle);
        write_reg(REG_SIT_ANKLE_ANGLE, v.sit_ankle_angle);
        write_reg(REG_LEFT_STEP_HIP, v.left_step_hip_angle);
        write_reg(REG_RIGHT_STEP_HIP, v.right_step_hip_angle);
        write_reg(REG_STAND_HIP_PERIOD, v.stand_hip_period);
        write_reg(REG_SIT_HIP_PERIOD, v.sit_hip_period);
        write_reg(REG_ANKLE_PERIOD, v.ankle_period);
        cfg_valid <= 1'b0;
    endtask

    // First three settings are the extremes: all ones, all zeros, and the legal top angles with unit periods.
    function automatic cfg_t phase_regs(input int p);
        cfg_t c;
        if (p == 0)
        begin
            c = '1;
        end
        else if (p == 1)
        begin
            c = '0;
        end
        else if (p == 2)
        begin
            c = {{5{8'd180}}, {3{8'd1}}};
        end
        else
        begin
            c.stand_angle = 8'(rand_angle());
            c.sit_hip_angle = 8'(rand_angle());
            c.sit_ankle_angle = 8'(rand_angle());
            c.left_step_hip_angle = 8'(rand_angle());
            c.right_step_hip_angle = 8'(rand_angle());
            c.stand_hip_period = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                               : $urandom_range(5, 255));
            c.sit_hip_period = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                             : $urandom_range(5, 255));
            c.ankle_period = 8'(($urandom_range(0, 9) < 7) ? $urandom_range(0, 4)
                                                           : $urandom_range(5, 40));
        end
        return c;
    endfunction

    // Waits until every command has been sent and every result has come back.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || in_valid || expected_poses.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                update_joints(drv_item, want);
                expected_poses.push_back(want);
                items_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (cmd_backlog.size() != 0)
                begin
                    drv_item = cmd_backlog.pop_front();
                    opcode <= drv_item.opcode;
                    pose <= drv_item.pose;
                    left_side <= drv_item.left_side;
                    set_left_hip <= drv_item.set_left_hip;
                    set_left_ankle <= drv_item.set_left_ankle;
                    set_right_hip <= drv_item.set_right_hip;
                    set_right_ankle <= drv_item.set_right_ankle;
                    in_valid <= 1'b1;
                    gap_left = pick_gap();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_poses.size() == 0)
                begin
                    if (errors < 10)
                    begin
                        $display("unexpected result transfer at cycle %0d", cycles);
                    end
                    errors++;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if ({left_hip_out, left_ankle_out, right_hip_out, right_ankle_out,
                         ramp_busy} !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display(
                                "result %0d: exp %0d %0d %0d %0d b%0d, got %0d %0d %0d %0d b%0d",
                                results_checked, want.left_hip, want.left_ankle,
                                want.right_hip, want.right_ankle, want.ramp_busy,
                                left_hip_out, left_ankle_out, right_hip_out,
                                right_ankle_out, ramp_busy);
                        end
                        errors++;
                    end
                    results_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (idle_on && $urandom_range(0, 5) == 0)
                begin
                    stall_left = pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("[four_joint_servo_pose_ramper] ERROR");
            $finish;
        end
    end

    initial
    begin
        int budget;
        int n;
        regs.stand_angle = RST_STAND_ANGLE;
        regs.sit_hip_angle = RST_SIT_HIP_ANGLE;
        regs.sit_ankle_angle = RST_SIT_ANKLE_ANGLE;
        regs.left_step_hip_angle = RST_LEFT_STEP_HIP;
        regs.right_step_hip_angle = RST_RIGHT_STEP_HIP;
        regs.stand_hip_period = RST_STAND_HIP_PERIOD;
        regs.sit_hip_period = RST_SIT_HIP_PERIOD;
        regs.ankle_period = RST_ANKLE_PERIOD;
        lh = 8'd90;
        la = 8'd90;
        rh = 8'd90;
        ra = 8'd90;
        hip_tgt = '0;
        ank_tgt = '0;
        hip_cnt = '0;
        ank_cnt = '0;
        ramp_on = 1'b0;
        ramp_sit = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands at the reset settings.
        cmd_backlog.push_back(make_cmd(OP_TICK, POSE_STAND, 1'b1, 255, 0, 255, 0));
        cmd_backlog.push_back(make_cmd(OP_NONE, POSE_STEP_SIT, 1'b1, 255, 255, 255, 255));
        cmd_backlog.push_back(make_cmd(OP_SET, POSE_SIT, 1'b0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_SET, POSE_SIT, 1'b0, 180, 180, 180, 180));
        cmd_backlog.push_back(make_cmd(OP_SET, POSE_SIT, 1'b0, 181, 255, 200, 179));
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_STEP, 1'b1, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_STEP, 1'b0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_STEP_SIT, 1'b1, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_STEP_SIT, 1'b0, 0, 0, 0, 0));
        // A stand from a standing pose must not start a ramp.
        cmd_backlog.push_back(make_cmd(OP_SET, POSE_SIT, 1'b0, 90, 90, 90, 90));
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_STAND, 1'b0, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_SET, POSE_SIT, 1'b0, 1, 1, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_SIT, 1'b1, 0, 0, 0, 0));
        // Everything but ticks is dropped while the sit ramp runs.
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_STAND, 1'b1, 0, 0, 0, 0));
        cmd_backlog.push_back(make_cmd(OP_SET, POSE_SIT, 1'b1, 45, 45, 45, 45));
        cmd_backlog.push_back(make_cmd(OP_NONE, POSE_STEP, 1'b0, 7, 7, 7, 7));
        add_ticks(32, n);
        cmd_backlog.push_back(make_cmd(OP_POSE, POSE_SIT, 1'b0, 0, 0, 0, 0));

        for (int p = 0; p < N_PHASES; p++)
        begin
            wait_drained();
            program_regs(phase_regs(p));
            idle_on = (p % 3) != 2;
            budget = 0;
            while (budget < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    add_ramp_seq(n);
                    budget += n;
                end
                else
                begin
                    cmd_backlog.push_back(random_cmd());
                    budget++;
                end
            end
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (expected_poses.size() != 0)
        begin
            $display("%0d expected results never arrived", expected_poses.size());
            errors++;
        end
        $display("Sent %0d commands and checked %0d results across %0d register settings.",
                 items_sent, results_checked, N_PHASES + 1);
        $display("Started %0d sit or stand ramps; %0d mismatches seen.", ramps_started, errors);
        if (errors == 0)
        begin
            $display("[four_joint_servo_pose_ramper] OK");
        end
        else
        begin
            $display("[four_joint_servo_pose_ramper] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/fjspr_pkg.sv
sv/fjspr_cfg_regs.sv
sv/fjspr_core.sv
sv/four_joint_servo_pose_ramper.sv
tb/four_joint_servo_pose_ramper_tb.sv
